// ===== src/framed_field_receiver_assert.svh =====
// assertion macros shared by the framed field receiver checker
// no dependencies; pulled in with an include by the files that assert

`ifndef FRAMED_FIELD_RECEIVER_ASSERT_SVH
`define FRAMED_FIELD_RECEIVER_ASSERT_SVH

// property checked on every rising clock edge while out of reset
`define FFR_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define FFR_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ffr_pkg.sv =====
// shared types, constants and helpers of the framed field receiver
// no dependencies

package ffr_pkg;

    localparam int FIELDS      = 4;
    localparam int BYTE_W      = 8;
    localparam int LANES       = 8;
    localparam int FIELD_W     = BYTE_W * LANES;
    localparam int SIZE_W      = 4;
    localparam int CFG_IDX_W   = 8;
    localparam int PHASE_W     = 3;
    localparam int LANE_W      = 3;
    localparam int FIELD_IDX_W = (FIELDS > 1) ? $clog2(FIELDS) : 1;

    // frame marker bytes
    localparam logic [BYTE_W-1:0] HDR_0 = 8'h01;
    localparam logic [BYTE_W-1:0] HDR_1 = 8'h02;
    localparam logic [BYTE_W-1:0] FTR_0 = 8'h03;
    localparam logic [BYTE_W-1:0] FTR_1 = 8'h04;

    // parser phases
    localparam logic [PHASE_W-1:0] PH_HUNT = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR1 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LOAD = 3'd2;
    localparam logic [PHASE_W-1:0] PH_FTR0 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_FTR1 = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_SIZE_0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_SIZE_1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_SIZE_2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_SIZE_3 = 8'd3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd4;

    typedef logic [BYTE_W-1:0]      t_byte;
    typedef logic [FIELD_W-1:0]     t_field;
    typedef logic [SIZE_W-1:0]      t_size;
    typedef logic [LANE_W-1:0]      t_lane;
    typedef logic [FIELD_IDX_W-1:0] t_fidx;
    typedef logic [PHASE_W-1:0]     t_phase;
    typedef logic [CFG_IDX_W-1:0]   t_cfg_idx;

    typedef t_field t_staging [FIELDS];
    typedef t_lane  t_last    [FIELDS];

    // parser status seen by the output stage
    typedef struct packed {
        logic footer_wait;   // next byte may complete a frame
        logic emit;          // accepted byte completes a frame
    } t_parse_stat;

    // last byte lane of a field, size 0 counts as 1 and sizes above 8 as 8
    function automatic t_lane last_lane(t_size s);
        t_lane l;
        if (s == '0) begin
            l = '0;
        end else if (s >= t_size'(LANES)) begin
            l = t_lane'(LANES - 1);
        end else begin
            l = t_lane'(s - t_size'(1));
        end
        return l;
    endfunction

    // keeps lanes 0..last of a field
    function automatic t_field lane_mask(t_lane last);
        t_field m;
        m = '0;
        for (int i = 0; i < LANES; i++) begin
            if (t_lane'(i) <= last) begin
                m[i*BYTE_W +: BYTE_W] = '1;
            end
        end
        return m;
    endfunction

endpackage

// ===== src/ffr_parser.sv =====
// header / payload / footer phase tracking and field staging
// depends on ffr_pkg

module ffr_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  ffr_pkg::t_byte      i_rx_byte,
    input  ffr_pkg::t_last      i_last,
    output ffr_pkg::t_parse_stat o_stat,
    output ffr_pkg::t_staging   o_staging
);
    import ffr_pkg::*;

    t_phase   r_phase, n_phase;
    t_fidx    r_field, n_field;
    t_lane    r_lane,  n_lane;
    t_staging r_staging;
    logic     w_emit;

    always_comb begin
        n_phase = r_phase;
        n_field = r_field;
        n_lane  = r_lane;
        w_emit  = 1'b0;
        if (i_take) begin
            case (r_phase)
                PH_HDR1: begin
                    if (i_rx_byte == HDR_1) begin
                        n_phase = PH_LOAD;
                        n_field = '0;
                        n_lane  = '0;
                    end else if (i_rx_byte == HDR_0) begin
                        n_phase = PH_HDR1;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LOAD: begin
                    if (r_lane >= i_last[r_field]) begin
                        n_lane = '0;
                        if (r_field == t_fidx'(FIELDS - 1)) begin
                            n_field = '0;
                            n_phase = PH_FTR0;
                        end else begin
                            n_field = r_field + t_fidx'(1);
                        end
                    end else begin
                        n_lane = r_lane + t_lane'(1);
                    end
                end
                PH_FTR0: begin
                    if (i_rx_byte == FTR_0) begin
                        n_phase = PH_FTR1;
                    end else if (i_rx_byte == HDR_0) begin
                        n_phase = PH_HDR1;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_FTR1: begin
                    if (i_rx_byte == FTR_1) begin
                        n_phase = PH_HUNT;
                        w_emit  = 1'b1;
                    end else if (i_rx_byte == HDR_0) begin
                        n_phase = PH_HDR1;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == HDR_0) ? PH_HDR1 : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_field <= '0;
            r_lane  <= '0;
        end else begin
            r_phase <= n_phase;
            r_field <= n_field;
            r_lane  <= n_lane;
        end
    end

    // staging starts at zero; lanes are never cleared between frames
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FIELDS; k++) begin
                r_staging[k] <= '0;
            end
        end else if (i_take && (r_phase == PH_LOAD)) begin
            r_staging[r_field][{r_lane, 3'b000} +: BYTE_W] <= i_rx_byte;
        end
    end

    assign o_stat.footer_wait = (r_phase == PH_FTR1);
    assign o_stat.emit        = w_emit;
    assign o_staging          = r_staging;

endmodule

// ===== src/framed_field_receiver.sv =====
// top level of the framed field receiver: config registers, parser, result register
// depends on ffr_pkg and ffr_parser

// Byte-serial frame parser. Bytes arrive on the rx channel, one item per
// cycle at full rate while input ready is high; each byte is handled by a
// compare and a byte-lane write, so it sustains one byte per cycle. A frame is
// the header 0x01 0x02, then field_size_0 + .. + field_size_3 payload bytes
// (each size 1..8, 0 read as 1 and 9..15 as 8) stored least significant byte
// first, then the footer 0x03 0x04. The result item appears in the output
// register the cycle after the final footer byte is taken and holds all four
// fields masked to their current widths. Input ready drops only when the
// parser waits for the final footer byte while the previous result has not
// been taken yet; every other byte is accepted even with a result pending.
// Sizes should be written only while no frame is in flight; the config port
// is always ready and ignores indexes beyond the four registers.

module framed_field_receiver (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // rx byte channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ffr_pkg::t_byte       i_rx_byte,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ffr_pkg::t_field      o_value_0,
    output ffr_pkg::t_field      o_value_1,
    output ffr_pkg::t_field      o_value_2,
    output ffr_pkg::t_field      o_value_3,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  ffr_pkg::t_cfg_idx    i_cfg_index,
    input  ffr_pkg::t_size       i_cfg_data
);
    import ffr_pkg::*;

    t_size       r_size [FIELDS];
    t_last       w_last;
    t_parse_stat w_stat;
    t_staging    w_staging;
    logic        w_take;
    logic        r_out_valid;
    t_field      r_value [FIELDS];

    // config writes are always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FIELDS; k++) begin
                r_size[k] <= SIZE_RESET;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FIELD_SIZE_0: r_size[0] <= i_cfg_data;
                REG_FIELD_SIZE_1: r_size[1] <= i_cfg_data;
                REG_FIELD_SIZE_2: r_size[2] <= i_cfg_data;
                REG_FIELD_SIZE_3: r_size[3] <= i_cfg_data;
                default: ;   // writes past the register list are dropped
            endcase
        end
    end

    // clamped last lane of each field, shared by parser and output mask
    always_comb begin
        for (int k = 0; k < FIELDS; k++) begin
            w_last[k] = last_lane(r_size[k]);
        end
    end

    // hold off only the byte that could complete a frame while a result waits
    assign o_in_ready = !(w_stat.footer_wait && r_out_valid && !i_out_ready);
    assign w_take     = i_in_valid && o_in_ready;

    ffr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_rx_byte (i_rx_byte),
        .i_last    (w_last),
        .o_stat    (w_stat),
        .o_staging (w_staging)
    );

    // result register: loads on a completed frame, clears once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // stale lanes above each width are masked off here
    always_ff @(posedge i_clk) begin
        if (w_stat.emit) begin
            for (int k = 0; k < FIELDS; k++) begin
                r_value[k] <= w_staging[k] & lane_mask(w_last[k]);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_0   = r_value[0];
    assign o_value_1   = r_value[1];
    assign o_value_2   = r_value[2];
    assign o_value_3   = r_value[3];

endmodule

// ===== src/ffr_checker.sv =====
// port-level checks for the framed field receiver, bound to the top level
// depends on ffr_pkg and framed_field_receiver_assert.svh

`include "framed_field_receiver_assert.svh"

module ffr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input ffr_pkg::t_byte     i_rx_byte,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ffr_pkg::t_field    o_value_0,
    input ffr_pkg::t_field    o_value_1,
    input ffr_pkg::t_field    o_value_2,
    input ffr_pkg::t_field    o_value_3
);
    import ffr_pkg::*;

    // a waiting result holds its value until taken
    `FFR_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value_0) && $stable(o_value_1) && $stable(o_value_2) && $stable(o_value_3), "result changed while stalled")

    // a new result follows an accepted final footer byte
    `FFR_ASSERT_RUN(a_out_cause, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready) && ($past(i_rx_byte) == FTR_1), "result without a footer byte")

    // input backpressure only while a result is stuck
    `FFR_ASSERT_RUN(a_in_stall, i_clk, i_rst_n, !o_in_ready |-> o_out_valid && !i_out_ready, "input stalled without a pending result")

    // reset empties the result register
    `FFR_ASSERT_ALL(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind framed_field_receiver ffr_checker u_ffr_checker (.*);

// ===== tb/sv/framed_field_receiver_tb.sv =====
// self-checking testbench for the framed field receiver: directed rows, then random frames
// depends on ffr_pkg and the framed_field_receiver rtl

module framed_field_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffr_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 4;     // result register loads at the edge that takes the last footer byte
    localparam int TAIL_CYCLES     = 8;
    localparam int WATCHDOG_CYCLES = 2000;  // cycles with no handshake at all
    localparam int RAND_PHASES     = 10;
    localparam int PHASE_ITEMS     = 200;
    localparam int DIR_ROWS        = 34;

    // register indexes past the end of the register list, must be ignored
    localparam t_cfg_idx REG_NONE_LOW = 8'd4;
    localparam t_cfg_idx REG_NONE_TOP = 8'hFF;

    typedef t_field [FIELDS-1:0] t_frame_vals;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    // width settings walked by the random phases
    typedef enum int {PLAN_NARROW, PLAN_WIDE, PLAN_ANY, PLAN_RESET, PLAN_MIXED} t_size_plan;

    typedef struct {
        t_row_kind   kind;
        t_cfg_idx    idx;
        t_byte       data;     // rx byte, or register value for config rows
        logic        pinned;   // result typed in by hand
        t_frame_vals vals;
    } t_dir_row;

    // dut ports
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_byte       i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    t_field      o_value_0;
    t_field      o_value_1;
    t_field      o_value_2;
    t_field      o_value_3;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index;
    t_size       i_cfg_data;

    // parser copy kept by the testbench
    t_size       size_reg [FIELDS] = '{default: SIZE_RESET};
    t_phase      rx_phase = PH_HUNT;
    logic [2:0]  fill_field = '0;
    t_lane       fill_lane = '0;
    t_field      field_store [FIELDS] = '{default: '0};

    // frames predicted but not yet seen on the result port
    t_frame_vals pending_frames [$];

    // hand-typed result for the directed row in flight
    logic        pinned_on = 1'b0;
    t_frame_vals pinned_vals = '0;

    int          bytes_taken = 0;
    int          cfg_taken = 0;
    int          frames_seen = 0;
    int          quiet_cycles = 0;
    int          error_count = 0;
    int          random_items = 0;
    int          in_gap_pct = 0;
    int          out_stall_pct = 0;

    t_cfg_idx    size_index [FIELDS] = '{REG_FIELD_SIZE_0, REG_FIELD_SIZE_1,
                                         REG_FIELD_SIZE_2, REG_FIELD_SIZE_3};

    // directed rows: out-of-range sizes, repeated header byte, byte extremes,
    // a width change in mid-frame, stale upper lanes, a broken footer
    t_dir_row script [DIR_ROWS] = '{
        '{ROW_CFG,  REG_FIELD_SIZE_0, 8'h00, 1'b0, '0},   // size 0 reads as one byte
        '{ROW_CFG,  REG_FIELD_SIZE_1, 8'h01, 1'b0, '0},
        '{ROW_CFG,  REG_FIELD_SIZE_2, 8'h01, 1'b0, '0},
        '{ROW_CFG,  REG_FIELD_SIZE_3, 8'h01, 1'b0, '0},
        '{ROW_CFG,  REG_NONE_LOW,     8'h02, 1'b0, '0},   // ignored
        '{ROW_CFG,  REG_NONE_TOP,     8'h09, 1'b0, '0},   // ignored
        '{ROW_BYTE, '0, HDR_0, 1'b0, '0},
        '{ROW_BYTE, '0, HDR_0, 1'b0, '0},                 // repeated 0x01 keeps the hunt
        '{ROW_BYTE, '0, HDR_1, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h80, 1'b0, '0},
        '{ROW_BYTE, '0, FTR_0, 1'b0, '0},
        '{ROW_BYTE, '0, FTR_1, 1'b1,
          {64'h80, 64'hFF, 64'h00, 64'hFF}},
        '{ROW_CFG,  REG_FIELD_SIZE_0, 8'h02, 1'b0, '0},
        '{ROW_BYTE, '0, HDR_0, 1'b0, '0},
        '{ROW_BYTE, '0, HDR_1, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hAA, 1'b0, '0},
        '{ROW_CFG,  REG_FIELD_SIZE_0, 8'h01, 1'b0, '0},   // shrink while lane 1 is next
        '{ROW_BYTE, '0, 8'hBB, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h11, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h22, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h33, 1'b0, '0},
        '{ROW_BYTE, '0, FTR_0, 1'b0, '0},
        '{ROW_BYTE, '0, FTR_1, 1'b0, '0},                 // lane 1 of field 0 masked off
        '{ROW_BYTE, '0, HDR_0, 1'b0, '0},
        '{ROW_BYTE, '0, HDR_1, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h44, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h55, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h66, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h77, 1'b0, '0},
        '{ROW_BYTE, '0, FTR_0, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h07, 1'b0, '0}                  // bad second footer byte, no frame
    };

    framed_field_receiver i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value_0   (o_value_0),
        .o_value_1   (o_value_1),
        .o_value_2   (o_value_2),
        .o_value_3   (o_value_3),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // byte count of a field: 0 reads as 1, anything above 8 as 8
    function automatic int lanes_of(input t_size s);
        if (s == '0) begin
            return 1;
        end
        if (s > t_size'(LANES)) begin
            return LANES;
        end
        return int'(s);
    endfunction

    function automatic t_field byte_mask(input int w);
        if (w >= LANES) begin
            return '1;
        end
        return (t_field'(1) << (BYTE_W * w)) - t_field'(1);
    endfunction

    // advance the parser copy by one byte, returns 1 when a frame completes
    function automatic bit parse_byte(input t_byte b, output t_frame_vals vals);
        int fi;
        int ln;
        int w;
        bit done;
        done = 1'b0;
        vals = '0;
        case (rx_phase)
            PH_HDR1: begin
                if (b == HDR_1) begin
                    rx_phase   = PH_LOAD;
                    fill_field = '0;
                    fill_lane  = '0;
                end else if (b == HDR_0) begin
                    rx_phase = PH_HDR1;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_LOAD: begin
                fi = int'(fill_field) % FIELDS;
                ln = int'(fill_lane);
                w  = lanes_of(size_reg[fi]);
                field_store[fi][ln*BYTE_W +: BYTE_W] = b;
                // current width decides, so a shrink mid-field closes it at once
                if (ln + 1 >= w) begin
                    fill_lane = '0;
                    if (fi + 1 >= FIELDS) begin
                        fill_field = '0;
                        rx_phase   = PH_FTR0;
                    end else begin
                        fill_field = 3'(fi + 1);
                    end
                end else begin
                    fill_lane = t_lane'(ln + 1);
                end
            end
            PH_FTR0: begin
                if (b == FTR_0) begin
                    rx_phase = PH_FTR1;
                end else if (b == HDR_0) begin
                    rx_phase = PH_HDR1;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_FTR1: begin
                if (b == FTR_1) begin
                    rx_phase = PH_HUNT;
                    for (int k = 0; k < FIELDS; k++) begin
                        vals[k] = field_store[k] & byte_mask(lanes_of(size_reg[k]));
                    end
                    done = 1'b1;
                end else if (b == HDR_0) begin
                    rx_phase = PH_HDR1;
                end else begin
                    rx_phase = PH_HUNT;
                end
            end
            default: begin
                rx_phase = (b == HDR_0) ? PH_HDR1 : PH_HUNT;
            end
        endcase
        return done;
    endfunction

    task automatic log_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // all handshakes are sampled here, on the rising edge
    always @(posedge i_clk) begin
        t_frame_vals got;
        t_frame_vals want;
        t_frame_vals calc;
        bit          hit;
        bit          moved;
        if (i_rst_n) begin
            moved = 1'b0;
            // check before predicting: a result never leaves on its own byte's edge
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                got = {o_value_3, o_value_2, o_value_1, o_value_0};
                if (pending_frames.size() == 0) begin
                    log_error($sformatf("frame %0d arrived with none pending", frames_seen));
                end else begin
                    want = pending_frames.pop_front();
                    for (int k = 0; k < FIELDS; k++) begin
                        if (got[k] !== want[k]) begin
                            log_error($sformatf("frame %0d value_%0d got %h want %h",
                                                frames_seen, k, got[k], want[k]));
                        end
                    end
                end
                frames_seen++;
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                hit = parse_byte(i_rx_byte, calc);
                if (pinned_on) begin
                    hit  = 1'b1;
                    calc = pinned_vals;
                end
                if (hit) begin
                    pending_frames.push_back(calc);
                end
                bytes_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                if (i_cfg_index < t_cfg_idx'(FIELDS)) begin
                    size_reg[i_cfg_index[FIELD_IDX_W-1:0]] = i_cfg_data;
                end
                cfg_taken++;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // stuck handshake guard
    always @(negedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side backpressure in bursts of random length
    initial begin
        int stall;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                i_out_ready = 1'b0;
            end else if (out_stall_pct > 0 && $urandom_range(1, 100) <= out_stall_pct) begin
                stall = $urandom_range(1, 5) - 1;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // one byte item, waits for its handshake; returns at a falling edge with valid high
    task automatic send_byte(input t_byte b, input bit tally = 1'b1);
        int target;
        if (in_gap_pct > 0 && $urandom_range(1, 100) <= in_gap_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_rx_byte  = b;
        target = bytes_taken + 1;
        while (bytes_taken < target) @(negedge i_clk);
        if (tally) begin
            random_items++;
        end
    endtask

    // stop sending until every predicted frame has come out
    task automatic hold_until_drained();
        i_in_valid = 1'b0;
        while (pending_frames.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_size val);
        int target;
        hold_until_drained();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        target = cfg_taken + 1;
        while (cfg_taken < target) @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_byte pick_payload();
        int c;
        c = $urandom_range(0, 9);
        case (c)
            0: return 8'h00;
            1: return 8'hFF;
            2: return HDR_0;
            3: return FTR_0;
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_byte pick_other(input t_byte a, input t_byte c);
        t_byte b;
        do begin
            b = t_byte'($urandom_range(0, 255));
        end while (b == a || b == c);
        return b;
    endfunction

    task automatic send_payload(input int n);
        for (int i = 0; i < n; i++) begin
            send_byte(pick_payload());
        end
    endtask

    task automatic apply_plan(input t_size_plan plan);
        t_size v;
        for (int k = 0; k < FIELDS; k++) begin
            case (plan)
                PLAN_NARROW: v = t_size'($urandom_range(0, 1));
                PLAN_WIDE:   v = t_size'($urandom_range(8, 15));
                PLAN_ANY:    v = t_size'($urandom_range(0, 15));
                PLAN_RESET:  v = SIZE_RESET;
                default:     v = t_size'($urandom_range(1, 3));
            endcase
            write_reg(size_index[k], v);
        end
    endtask

    // mostly clean frames with random content, some broken ones and some noise
    task automatic send_frame();
        int kind;
        int pay_len;
        kind = $urandom_range(0, 99);
        pay_len = 0;
        for (int k = 0; k < FIELDS; k++) begin
            pay_len += lanes_of(size_reg[k]);
        end
        if (kind < 10) begin
            // line noise between frames
            repeat ($urandom_range(1, 6)) send_byte(pick_payload(), 1'b0);
        end else begin
            if ($urandom_range(0, 4) == 0) begin
                send_byte(HDR_0);
            end
            send_byte(HDR_0);
            send_byte(HDR_1);
            if (kind < 80) begin
                send_payload(pay_len);
                send_byte(FTR_0);
                send_byte(FTR_1);
                // no pauses once the run goes flat out
                if ((in_gap_pct > 0 || out_stall_pct > 0) && $urandom_range(0, 29) == 0) begin
                    hold_until_drained();
                end
            end else begin
                case ($urandom_range(0, 4))
                    0: begin
                        send_payload(pay_len);
                        send_byte(HDR_0);
                    end
                    1: begin
                        send_payload(pay_len);
                        send_byte(pick_other(FTR_0, HDR_0));
                    end
                    2: begin
                        send_payload(pay_len);
                        send_byte(FTR_0);
                        send_byte(HDR_0);
                    end
                    3: begin
                        send_payload(pay_len);
                        send_byte(FTR_0);
                        send_byte(pick_other(FTR_1, HDR_0));
                    end
                    default: begin
                        // cut short, the next header lands in the payload
                        send_payload($urandom_range(0, pay_len - 1));
                    end
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_rx_byte   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows
        in_gap_pct    = 20;
        out_stall_pct = 20;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (script[r].kind == ROW_CFG) begin
                write_reg(script[r].idx, t_size'(script[r].data));
            end else begin
                pinned_on   = script[r].pinned;
                pinned_vals = script[r].vals;
                send_byte(script[r].data, 1'b0);
                pinned_on   = 1'b0;
            end
        end

        // random phases, each under its own width setting; the last one runs flat out
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == RAND_PHASES - 1) begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end else begin
                in_gap_pct    = (ph % 3 == 0) ? 0 : $urandom_range(10, 40);
                out_stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(10, 50);
            end
            apply_plan(t_size_plan'(ph % 5));
            while (random_items < (ph + 1) * PHASE_ITEMS) begin
                send_frame();
            end
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
